// ===== hw/rtl/lifo_stack_remove_first_negative_core_macros.svh =====
// Assertion macros shared by the stack core modules.
`ifndef LIFO_STACK_REMOVE_FIRST_NEGATIVE_CORE_MACROS_SVH
`define LIFO_STACK_REMOVE_FIRST_NEGATIVE_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define LSRFN_ASSERT_ALWAYS(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("lsrfn assertion failed");

`define LSRFN_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsrfn assertion failed");

`else

`define LSRFN_ASSERT_ALWAYS(name, clk, rst_n, expr)

`define LSRFN_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/lsrfn_pkg.sv =====
// Shared constants, codes and controller/datapath interface types of the stack core.
`default_nettype none

package lsrfn_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int DATA_W      = 32;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int FILL_W      = 5;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH   = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_NOP    = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_NONEG = 2'd2,
        STATUS_FULL  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        OP_IDLE       = 4'd0,
        OP_LOAD       = 4'd1,
        OP_PUSH       = 4'd2,
        OP_POP_EMPTY  = 4'd3,
        OP_RD_TOP     = 4'd4,
        OP_POP_DONE   = 4'd5,
        OP_RD_DOWN    = 4'd6,
        OP_RD_UP      = 4'd7,
        OP_RM_TOP     = 4'd8,
        OP_RM_NONE    = 4'd9,
        OP_SHIFT      = 4'd10,
        OP_SHIFT_LAST = 4'd11,
        OP_NOP_DONE   = 4'd12
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        t_func func;
        logic  empty;
        logic  full;
        logic  neg;
        logic  at_bottom;
        logic  at_top;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/lsrfn_dp.sv =====
// Datapath of the stack core: entry memory, count, scan and shift pointers, result registers.
`default_nettype none
`include "lifo_stack_remove_first_negative_core_macros.svh"

module lsrfn_dp (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire lsrfn_pkg::t_dp_cmd                    i_cmd,
    input  wire logic [lsrfn_pkg::FUNC_W-1:0]          i_func,
    input  wire logic signed [lsrfn_pkg::DATA_W-1:0]   i_push_value,
    output lsrfn_pkg::t_dp_stat                        o_stat,
    output logic                                       o_valid,
    output logic signed [lsrfn_pkg::DATA_W-1:0]        o_popped_value,
    output logic [lsrfn_pkg::STATUS_W-1:0]             o_status,
    output logic [lsrfn_pkg::FILL_W-1:0]               o_fill_level
);
    import lsrfn_pkg::*;

    logic [DATA_W-1:0] r_mem [STACK_DEPTH];

    t_func             r_func;
    t_func             n_func;
    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] n_value;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [DATA_W-1:0] r_rdata;
    logic [ADDR_W-1:0] r_raddr;
    logic [ADDR_W-1:0] r_wptr;
    logic [ADDR_W-1:0] n_wptr;
    logic              r_valid;
    logic              n_valid;
    logic [DATA_W-1:0] r_popped;
    logic [DATA_W-1:0] n_popped;
    t_status           r_status;
    t_status           n_status;
    logic [FILL_W-1:0] r_fill;

    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [DATA_W-1:0]       wr_data;
    logic [CNT_W-1:0]        count_m1;
    logic [ADDR_W-1:0]       top_addr;
    logic                    is_full;
    logic                    is_empty;
    logic [FILL_W+CNT_W-1:0] fill_ext;

    assign count_m1 = r_count - 1'b1;
    assign top_addr = count_m1[ADDR_W-1:0];
    assign is_full  = (r_count == CNT_W'(STACK_DEPTH));
    assign is_empty = (r_count == '0);
    assign fill_ext = {{FILL_W{1'b0}}, n_count};

    always_comb begin
        n_func   = r_func;
        n_value  = r_value;
        n_count  = r_count;
        n_wptr   = r_wptr;
        n_valid  = 1'b0;
        n_popped = r_popped;
        n_status = r_status;
        rd_en    = 1'b0;
        rd_addr  = r_raddr;
        wr_en    = 1'b0;
        wr_addr  = r_count[ADDR_W-1:0];
        wr_data  = r_value;
        case (i_cmd.op)
            OP_LOAD: begin
                n_func  = t_func'(i_func);
                n_value = i_push_value;
            end
            OP_PUSH: begin
                n_valid  = 1'b1;
                n_popped = '0;
                if (is_full) begin
                    n_status = STATUS_FULL;
                end else begin
                    wr_en    = 1'b1;
                    n_count  = r_count + 1'b1;
                    n_status = STATUS_OK;
                end
            end
            OP_POP_EMPTY: begin
                n_valid  = 1'b1;
                n_popped = '1;
                n_status = STATUS_EMPTY;
            end
            OP_RD_TOP: begin
                rd_en   = 1'b1;
                rd_addr = top_addr;
            end
            OP_POP_DONE: begin
                n_valid  = 1'b1;
                n_popped = r_rdata;
                n_count  = count_m1;
                n_status = STATUS_OK;
            end
            OP_RD_DOWN: begin
                rd_en   = 1'b1;
                rd_addr = r_raddr - 1'b1;
            end
            OP_RD_UP: begin
                rd_en   = 1'b1;
                rd_addr = r_raddr + 1'b1;
                n_wptr  = r_raddr;
            end
            OP_RM_TOP: begin
                n_valid  = 1'b1;
                n_popped = '0;
                n_count  = count_m1;
                n_status = STATUS_OK;
            end
            OP_RM_NONE: begin
                n_valid  = 1'b1;
                n_popped = '0;
                n_status = STATUS_NONEG;
            end
            OP_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = r_wptr;
                wr_data = r_rdata;
                n_wptr  = r_wptr + 1'b1;
                rd_en   = 1'b1;
                rd_addr = r_raddr + 1'b1;
            end
            OP_SHIFT_LAST: begin
                wr_en    = 1'b1;
                wr_addr  = r_wptr;
                wr_data  = r_rdata;
                n_valid  = 1'b1;
                n_popped = '0;
                n_count  = count_m1;
                n_status = STATUS_OK;
            end
            OP_NOP_DONE: begin
                n_valid  = 1'b1;
                n_popped = '0;
                n_status = STATUS_OK;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
            r_raddr <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func  <= n_func;
        r_value <= n_value;
        r_wptr  <= n_wptr;
        if (n_valid) begin
            r_popped <= n_popped;
            r_status <= n_status;
            r_fill   <= fill_ext[FILL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    assign o_stat.func      = r_func;
    assign o_stat.empty     = is_empty;
    assign o_stat.full      = is_full;
    assign o_stat.neg       = r_rdata[DATA_W-1];
    assign o_stat.at_bottom = (r_raddr == '0);
    assign o_stat.at_top    = (r_raddr == top_addr);

    assign o_valid        = r_valid;
    assign o_popped_value = r_popped;
    assign o_status       = r_status;
    assign o_fill_level   = r_fill;

    `LSRFN_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(STACK_DEPTH))
    `LSRFN_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, r_valid, !r_valid)
    `LSRFN_ASSERT_NEXT(a_shift_drops_one, i_clk, i_rst_n, i_cmd.op == OP_SHIFT_LAST, r_count == $past(r_count) - 1'b1)

endmodule

`default_nettype wire

// ===== hw/rtl/lsrfn_ctrl.sv =====
// Controller state machine of the stack core: sequences push, pop, scan and shift.
`default_nettype none
`include "lifo_stack_remove_first_negative_core_macros.svh"

module lsrfn_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire lsrfn_pkg::t_dp_stat  i_stat,
    output lsrfn_pkg::t_dp_cmd        o_cmd,
    output logic                      o_busy
);
    import lsrfn_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_POPRD  = 5'b00100,
        S_SCAN   = 5'b01000,
        S_SHIFT  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_IDLE;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                case (i_stat.func)
                    FUNC_PUSH: begin
                        o_cmd.op = OP_PUSH;
                    end
                    FUNC_POP: begin
                        if (i_stat.empty) begin
                            o_cmd.op = OP_POP_EMPTY;
                        end else begin
                            o_cmd.op = OP_RD_TOP;
                            n_state  = S_POPRD;
                        end
                    end
                    FUNC_REMOVE: begin
                        if (i_stat.empty) begin
                            o_cmd.op = OP_RM_NONE;
                        end else begin
                            o_cmd.op = OP_RD_TOP;
                            n_state  = S_SCAN;
                        end
                    end
                    default: begin
                        o_cmd.op = OP_NOP_DONE;
                    end
                endcase
            end
            S_POPRD: begin
                o_cmd.op = OP_POP_DONE;
                n_state  = S_IDLE;
            end
            S_SCAN: begin
                if (i_stat.neg) begin
                    if (i_stat.at_top) begin
                        o_cmd.op = OP_RM_TOP;
                        n_state  = S_IDLE;
                    end else begin
                        o_cmd.op = OP_RD_UP;
                        n_state  = S_SHIFT;
                    end
                end else if (i_stat.at_bottom) begin
                    o_cmd.op = OP_RM_NONE;
                    n_state  = S_IDLE;
                end else begin
                    o_cmd.op = OP_RD_DOWN;
                end
            end
            S_SHIFT: begin
                if (i_stat.at_top) begin
                    o_cmd.op = OP_SHIFT_LAST;
                    n_state  = S_IDLE;
                end else begin
                    o_cmd.op = OP_SHIFT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    `LSRFN_ASSERT_NEXT(a_start_decodes, i_clk, i_rst_n, r_state == S_IDLE && i_start, r_state == S_DECODE)
    `LSRFN_ASSERT_NEXT(a_pop_one_read, i_clk, i_rst_n, r_state == S_POPRD, r_state == S_IDLE)
    `LSRFN_ASSERT_NEXT(a_scan_ends, i_clk, i_rst_n, r_state == S_SCAN && !i_stat.neg && i_stat.at_bottom, r_state == S_IDLE)

endmodule

`default_nettype wire

// ===== hw/rtl/lifo_stack_remove_first_negative_core.sv =====
// Top level of the bounded stack core with remove-first-negative operation.
//
//   Channel   Handshake                     Ports
//   request   start && !busy at the edge    i_func, i_push_value
//   result    o_valid, one cycle, no stall  o_popped_value, o_status, o_fill_level
//
// A result follows the decode step for push and the unused code, one entry read for pop,
// and for remove a scan down from the top entry to the first negative one, then a shift
// that moves each entry above that one down by one place.
// Reset clears the entry count; the entry memory holds no reset value and needs no clearing.
// The receiver cannot stall: busy falls in the cycle the result is shown.
`default_nettype none

module lifo_stack_remove_first_negative_core (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [lsrfn_pkg::FUNC_W-1:0]          i_func,
    input  wire logic signed [lsrfn_pkg::DATA_W-1:0]   i_push_value,
    output logic                                       o_valid,
    output logic signed [lsrfn_pkg::DATA_W-1:0]        o_popped_value,
    output logic [lsrfn_pkg::STATUS_W-1:0]             o_status,
    output logic [lsrfn_pkg::FILL_W-1:0]               o_fill_level
);
    import lsrfn_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    lsrfn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    lsrfn_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_func         (i_func),
        .i_push_value   (i_push_value),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_fill_level   (o_fill_level)
    );

endmodule

`default_nettype wire
